/* sv/edf_pkg.sv */
// Package: register map, field widths and reset values for the EDF priority ranker.
package edf_pkg;

  localparam int NUM_PERIOD_REGS = 4;
  localparam int CNT_W           = 3;
  localparam int PERIOD_W        = 16;
  localparam int NOW_W           = 16;
  localparam int RANK_W          = 2;
  localparam int TIDX_W          = 2;
  localparam int PRIO_W          = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_TASK_COUNT = 3'd0;
  localparam cfg_idx_t REG_PERIOD0    = 3'd1;
  localparam cfg_idx_t REG_PERIOD3    = 3'd4;

  localparam logic [CNT_W-1:0] TASK_COUNT_RESET = 3'd3;

  typedef logic [PERIOD_W-1:0] period_t;

  localparam period_t PERIOD_RESET [NUM_PERIOD_REGS] = '{
    16'd350, 16'd280, 16'd250, 16'd1000
  };

endpackage

/* sv/edf_priority_ranker_core.sv */
// EDF priority ranker: bit-serial modulo per task, odd-even sort, ranked result stream.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | in_now
//   out     | output    | out_valid / out_stall| rank, task_index, priority_res,
//           |           |                      | time_to_deadline, last
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A request passes through the restoring modulo unit, which retires one bit of now per
// cycle and visits the n tasks in turn, and then through the odd-even sort before its
// first result; results follow one per cycle while out_stall is low.
// rst_n is synchronous; it clears control state and reloads the register defaults.
// in_stall is high from acceptance until the last result is loaded into the output
// register; out_stall only holds the output register.
module edf_priority_ranker_core #(
  parameter int MAX_TASKS = 4,
  parameter int TICK_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [edf_pkg::NOW_W-1:0]      in_now,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [edf_pkg::RANK_W-1:0]     out_rank,
  output logic [edf_pkg::TIDX_W-1:0]     out_task_index,
  output logic [edf_pkg::PRIO_W-1:0]     out_priority_res,
  output logic [edf_pkg::PERIOD_W-1:0]   out_time_to_deadline,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [edf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [edf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import edf_pkg::*;

  localparam int SLOTS = (MAX_TASKS < NUM_PERIOD_REGS) ? MAX_TASKS : NUM_PERIOD_REGS;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NB    = (TICK_BITS < NOW_W) ? TICK_BITS : NOW_W;
  localparam int BC_W  = $clog2(NB);
  localparam int PIDX_W = $clog2(NUM_PERIOD_REGS);

  localparam logic [CNT_W-1:0] SLOTS_C    = CNT_W'(SLOTS);
  localparam logic [SW-1:0]    LAST_ROUND = SW'(SLOTS - 1);
  localparam logic [BC_W-1:0]  LAST_BIT   = BC_W'(NB - 1);

  typedef enum logic [1:0] {S_IDLE, S_MOD, S_SORT, S_OUT} state_t;

  state_t                state_r;
  logic [CNT_W-1:0]      task_count_r;
  period_t               period_r [NUM_PERIOD_REGS];
  logic [CNT_W-1:0]      n_r;
  logic [NB-1:0]         now_r;
  logic [NB-1:0]         now_sh_r;
  logic [PERIOD_W-1:0]   rem_r;
  logic [BC_W-1:0]       bit_r;
  logic [SW-1:0]         task_r;
  logic [SW-1:0]         round_r;
  logic [SW-1:0]         slot_r;
  logic [PERIOD_W-1:0]   dl_r  [SLOTS];
  logic [TIDX_W-1:0]     ord_r [SLOTS];

  logic                  out_valid_r;
  logic [RANK_W-1:0]     out_rank_r;
  logic [TIDX_W-1:0]     out_tidx_r;
  logic [PRIO_W-1:0]     out_prio_r;
  logic [PERIOD_W-1:0]   out_ttd_r;
  logic                  out_last_r;

  logic [CNT_W-1:0]      n_eff;
  logic [PERIOD_W:0]     pz;
  logic [PERIOD_W:0]     rem_sh;
  logic                  rem_ge;
  logic [PERIOD_W-1:0]   rem_new;
  logic [PERIOD_W-1:0]   dl_new;
  logic                  task_last;
  logic                  slot_last;
  logic                  out_free;

  always_comb begin
    if (task_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (task_count_r > SLOTS_C) begin
      n_eff = SLOTS_C;
    end else begin
      n_eff = task_count_r;
    end
  end

  // restoring modulo step: one bit of now per cycle
  always_comb begin
    pz      = {1'b0, period_r[PIDX_W'(task_r)]};
    if (pz == '0) begin
      pz = (PERIOD_W+1)'(1);
    end
    rem_sh  = {rem_r, now_sh_r[NB-1]};
    rem_ge  = (rem_sh >= pz);
    rem_new = rem_ge ? PERIOD_W'(rem_sh - pz) : PERIOD_W'(rem_sh);
    dl_new  = PERIOD_W'(pz - {1'b0, rem_new});
  end

  assign task_last = ({{(CNT_W-SW){1'b0}}, task_r} == n_r - CNT_W'(1));
  assign slot_last = ({{(CNT_W-SW){1'b0}}, slot_r} == n_r - CNT_W'(1));
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      task_count_r <= TASK_COUNT_RESET;
      for (int k = 0; k < NUM_PERIOD_REGS; k++) begin
        period_r[k] <= PERIOD_RESET[k];
      end
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_TASK_COUNT) begin
          task_count_r <= CNT_W'(cfg_data);
        end else if (cfg_index >= REG_PERIOD0 && cfg_index <= REG_PERIOD3) begin
          period_r[PIDX_W'(cfg_index - REG_PERIOD0)] <= PERIOD_W'(cfg_data);
        end
      end

      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            n_r      <= n_eff;
            now_r    <= in_now[NB-1:0];
            now_sh_r <= in_now[NB-1:0];
            rem_r    <= '0;
            bit_r    <= '0;
            task_r   <= '0;
            state_r  <= S_MOD;
          end
        end
        S_MOD: begin
          if (bit_r == LAST_BIT) begin
            dl_r[task_r]  <= dl_new;
            ord_r[task_r] <= TIDX_W'(task_r);
            now_sh_r      <= now_r;
            rem_r         <= '0;
            bit_r         <= '0;
            task_r        <= task_r + SW'(1);
            if (task_last) begin
              round_r <= '0;
              state_r <= S_SORT;
            end
          end else begin
            now_sh_r <= {now_sh_r[NB-2:0], 1'b0};
            rem_r    <= rem_new;
            bit_r    <= bit_r + BC_W'(1);
          end
        end
        S_SORT: begin
          // odd-even transposition; swap only on strictly greater keeps ties stable
          for (int j = 0; j < SLOTS - 1; j++) begin
            if ((j % 2) == int'(round_r[0]) && CNT_W'(j + 1) < n_r &&
                dl_r[j] > dl_r[j+1]) begin
              dl_r[j]    <= dl_r[j+1];
              dl_r[j+1]  <= dl_r[j];
              ord_r[j]   <= ord_r[j+1];
              ord_r[j+1] <= ord_r[j];
            end
          end
          round_r <= round_r + SW'(1);
          if (round_r == LAST_ROUND) begin
            slot_r  <= '0;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_rank_r  <= RANK_W'(slot_r);
            out_tidx_r  <= ord_r[slot_r];
            out_prio_r  <= PRIO_W'(n_r - CNT_W'(slot_r));
            out_ttd_r   <= dl_r[slot_r];
            out_last_r  <= slot_last;
            slot_r      <= slot_r + SW'(1);
            if (slot_last) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall             = (state_r != S_IDLE);
  assign cfg_ready            = 1'b1;
  assign out_valid            = out_valid_r;
  assign out_rank             = out_rank_r;
  assign out_task_index       = out_tidx_r;
  assign out_priority_res     = out_prio_r;
  assign out_time_to_deadline = out_ttd_r;
  assign out_last             = out_last_r;

`ifndef SYNTHESIS
  a_rem_below_period: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MOD |-> {1'b0, rem_r} < pz)
    else $error("modulo remainder not below period");

  a_accept_starts_mod: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_MOD)
    else $error("accepted request did not start modulo");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> {{(CNT_W-SW){1'b0}}, slot_r} < n_r)
    else $error("output slot beyond task count");

  a_prio_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_prio_r != '0)
    else $error("zero priority emitted");
`endif

endmodule
